>>> src/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// Request and response payload structs, request codes and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

	localparam int SLOTS = 1024;
	localparam int IDX_W = 10;
	localparam int GEN_W = 16;
	localparam int CNT_W = 11;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_CHECK   = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] handle_index;
		logic [GEN_W-1:0] handle_generation;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] out_index;
		logic [GEN_W-1:0] out_generation;
	} rsp_t;

endpackage

`default_nettype wire

>>> src/generational_handle_allocator.sv
// Generational handle allocator: allocate, release and check slot handles.
// Depends on gha_pkg for the payload structs and codes.
//
// Usage:
//   A request transfers at a rising edge with start high and busy low; busy
//   is always low, so one request can be issued every cycle. Each request
//   gives exactly one response on rsp, marked by done for one cycle.
//   The request's table and free stack reads are registered at the transfer
//   edge, the decision and the memory writes happen in the next cycle, and
//   the response register loads at its end.
//   Throughput is one request per cycle, set by the single table port and
//   the single free stack port, with write-to-read bypass on both.
//   The free stack keeps each released index together with its advanced
//   generation, so an allocation needs a single stack read.
//   Live marks of slots never handed out are masked by the fresh index
//   counter, so reset takes effect at once with no clearing pass.
//   Reset clears fc_q, vld_s1 and done_q and sets fn_q to 1; no response is in flight.
//   The receiver cannot stall: a response must be taken in its done cycle.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  gha_pkg::req_t   req,
	output logic            done,
	output gha_pkg::rsp_t   rsp
);

	typedef struct packed {
		logic                      live;
		logic [gha_pkg::GEN_W-1:0] gen;
	} tbl_ent_t;

	typedef struct packed {
		logic [gha_pkg::IDX_W-1:0] idx;
		logic [gha_pkg::GEN_W-1:0] gen;
	} stk_ent_t;

	function automatic logic [gha_pkg::GEN_W-1:0] next_gen(
		input logic [gha_pkg::GEN_W-1:0] g
	);
		logic [gha_pkg::GEN_W-1:0] n;
		n = g + gha_pkg::GEN_W'(1);
		if (n == '0)
			n = gha_pkg::GEN_W'(1);
		return n;
	endfunction

	tbl_ent_t tbl_mem [gha_pkg::SLOTS];
	stk_ent_t stk_mem [gha_pkg::SLOTS];

	logic                      vld_s1;
	gha_pkg::req_t             req_s1;
	tbl_ent_t                  tbl_rd_s1;
	stk_ent_t                  stk_rd_s1;
	logic [gha_pkg::CNT_W-1:0] fc_q;
	logic [gha_pkg::CNT_W-1:0] fn_q;
	logic                      done_q;
	gha_pkg::rsp_t             rsp_q;

	logic                      tbl_we;
	logic [gha_pkg::IDX_W-1:0] tbl_wa;
	tbl_ent_t                  tbl_wd;
	logic                      stk_we;
	logic [gha_pkg::IDX_W-1:0] stk_wa;
	stk_ent_t                  stk_wd;
	logic [gha_pkg::IDX_W-1:0] stk_ra;
	logic [gha_pkg::CNT_W-1:0] fc_d;
	logic [gha_pkg::CNT_W-1:0] fn_d;
	gha_pkg::rsp_t             rsp_d;
	logic                      live;
	logic                      hv;
	logic [gha_pkg::CNT_W-1:0] fc_m1;

	assign busy = 1'b0;
	assign done = done_q;
	assign rsp  = rsp_q;

	// slots at or above the fresh counter were never written
	assign live = tbl_rd_s1.live &&
		({1'b0, req_s1.handle_index} < fn_q);
	assign hv = (req_s1.handle_index != '0) && live &&
		(tbl_rd_s1.gen == req_s1.handle_generation);

	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = req_s1.handle_index;
		tbl_wd = '0;
		stk_we = 1'b0;
		stk_wa = fc_q[gha_pkg::IDX_W-1:0];
		stk_wd = '0;
		fc_d   = fc_q;
		fn_d   = fn_q;
		rsp_d  = '0;
		rsp_d.status = gha_pkg::ST_BAD;
		case (req_s1.req_type)
			gha_pkg::REQ_ALLOC: begin
				if (fc_q != '0) begin
					fc_d         = fc_q - gha_pkg::CNT_W'(1);
					tbl_we       = vld_s1;
					tbl_wa       = stk_rd_s1.idx;
					tbl_wd.live  = 1'b1;
					tbl_wd.gen   = stk_rd_s1.gen;
					rsp_d.status = gha_pkg::ST_OK;
					rsp_d.out_index      = stk_rd_s1.idx;
					rsp_d.out_generation = stk_rd_s1.gen;
				end else if (fn_q < gha_pkg::CNT_W'(gha_pkg::SLOTS)) begin
					fn_d         = fn_q + gha_pkg::CNT_W'(1);
					tbl_we       = vld_s1;
					tbl_wa       = fn_q[gha_pkg::IDX_W-1:0];
					tbl_wd.live  = 1'b1;
					tbl_wd.gen   = gha_pkg::GEN_W'(1);
					rsp_d.status = gha_pkg::ST_OK;
					rsp_d.out_index      = fn_q[gha_pkg::IDX_W-1:0];
					rsp_d.out_generation = gha_pkg::GEN_W'(1);
				end else begin
					rsp_d.status = gha_pkg::ST_FULL;
				end
			end
			gha_pkg::REQ_RELEASE: begin
				if (hv) begin
					tbl_we       = vld_s1;
					tbl_wd.live  = 1'b0;
					tbl_wd.gen   = next_gen(tbl_rd_s1.gen);
					rsp_d.status = gha_pkg::ST_OK;
					if (fc_q < gha_pkg::CNT_W'(gha_pkg::SLOTS)) begin
						stk_we     = vld_s1;
						stk_wd.idx = req_s1.handle_index;
						stk_wd.gen = next_gen(tbl_rd_s1.gen);
						fc_d       = fc_q + gha_pkg::CNT_W'(1);
					end
				end
			end
			gha_pkg::REQ_CHECK: begin
				if (hv)
					rsp_d.status = gha_pkg::ST_OK;
			end
			default: begin
				rsp_d.status = gha_pkg::ST_BAD;
			end
		endcase
		if (!vld_s1) begin
			fc_d = fc_q;
			fn_d = fn_q;
		end
	end

	// pop address for the next request, after this cycle's update
	assign fc_m1  = fc_d - gha_pkg::CNT_W'(1);
	assign stk_ra = fc_m1[gha_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_wa] <= tbl_wd;
		if (tbl_we && (tbl_wa == req.handle_index))
			tbl_rd_s1 <= tbl_wd;
		else
			tbl_rd_s1 <= tbl_mem[req.handle_index];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[stk_wa] <= stk_wd;
		if (stk_we && (stk_wa == stk_ra))
			stk_rd_s1 <= stk_wd;
		else
			stk_rd_s1 <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
		rsp_q  <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
			fc_q   <= '0;
			fn_q   <= gha_pkg::CNT_W'(1);
		end else begin
			vld_s1 <= start && !busy;
			done_q <= vld_s1;
			fc_q   <= fc_d;
			fn_q   <= fn_d;
		end
	end

endmodule

`default_nettype wire

>>> src/gha_checker.sv
// Port-level checks for the generational handle allocator, bound to the top.
// Depends on gha_pkg for the payload structs and codes.
`timescale 1ns / 1ps
`default_nettype none

module gha_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           start,
	input wire           busy,
	input gha_pkg::req_t req,
	input wire           done,
	input gha_pkg::rsp_t rsp
);

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("transfer without response two cycles later");

	a_full_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == gha_pkg::ST_FULL)) |->
		($past(req.req_type, 2) == gha_pkg::REQ_ALLOC))
		else $error("full status on a non-allocate request");

	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == gha_pkg::ST_OK) &&
		($past(req.req_type, 2) == gha_pkg::REQ_ALLOC)) |->
		((rsp.out_index != '0) && (rsp.out_generation != '0)))
		else $error("allocation returned the reserved index or generation zero");

	a_other_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (($past(req.req_type, 2) != gha_pkg::REQ_ALLOC) ||
		(rsp.status != gha_pkg::ST_OK))) |->
		((rsp.out_index == '0) && (rsp.out_generation == '0)))
		else $error("handle fields nonzero on a response with no allocation");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire
